@@ rtl/core/nnis_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared sizes, register indexes, word codes and helpers for the
// nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int MAX_OUT_SIZE   = 1024;

    localparam int COORD_W    = 10;
    localparam int SRC_SIZE_W = 9;
    localparam int OUT_SIZE_W = 11;
    localparam int PIX_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int SX_W   = $clog2(MAX_SRC_WIDTH);
    localparam int SY_W   = $clog2(MAX_SRC_HEIGHT);
    localparam int Q_W    = (SX_W > SY_W) ? SX_W : SY_W;
    localparam int STEP_W = (Q_W > 1) ? $clog2(Q_W) : 1;
    localparam int DEN_W  = OUT_SIZE_W + 1;
    localparam int REM_W  = DEN_W + Q_W;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int SIZE_RESET = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_OUT_WIDTH  = 2'd2,
        CFG_OUT_HEIGHT = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_RESP
    } t_state;

    // zero acts as one, values above the maximum saturate
    function automatic logic [OUT_SIZE_W-1:0] clamp_size(
        input logic [OUT_SIZE_W-1:0] v,
        input logic [OUT_SIZE_W-1:0] maxv
    );
        logic [OUT_SIZE_W-1:0] r;
        if (v == '0) begin
            r = OUT_SIZE_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/nearest_neighbor_image_scaler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Frame store with center-sampled nearest-neighbor read-out.
//
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_stall   i_op i_col i_row i_pixel
//  out      source     o_out_valid / i_out_stall o_pixel_out o_range_error
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// A write word goes into the frame store on acceptance if it lies inside
// the source size, else it is dropped. For a read word the accept cycle
// forms both numerators, a restoring divider pair retires one quotient bit
// per cycle, then the store is read in ST_RD and the output register is
// loaded in ST_RESP. An out-of-range read goes straight to ST_RESP.
// A stalled result holds the output register; the next word is still taken,
// and a read waits in its last state until that register is free.
// Synchronous active-low reset clears control and sets the size registers to 256 only.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [nnis_pkg::COORD_W-1:0]    i_col,
    input  logic [nnis_pkg::COORD_W-1:0]    i_row,
    input  logic [nnis_pkg::PIX_W-1:0]      i_pixel,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [nnis_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                            o_range_error,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nnis_pkg::*;

    t_state r_state, n_state;

    logic [SRC_SIZE_W-1:0] r_src_w, r_src_h;
    logic [OUT_SIZE_W-1:0] r_out_w, r_out_h;

    logic [SRC_SIZE_W-1:0] w_eff, h_eff;
    logic [OUT_SIZE_W-1:0] ow_eff, oh_eff;

    logic [REM_W-1:0]  r_rem_x, r_rem_y;
    logic [DEN_W-1:0]  r_den_x, r_den_y;
    logic [Q_W-1:0]    r_qx, r_qy;
    logic [STEP_W-1:0] r_step;
    logic              r_err;

    logic [PIX_W-1:0]  mem [STORE_DEPTH];
    logic [PIX_W-1:0]  r_rdata;

    logic              r_out_valid;
    logic [PIX_W-1:0]  r_pixel_out;
    logic              r_range_error;

    logic in_acc, cfg_acc, out_free;
    logic is_read, rd_range_err, wr_in_range;
    logic mem_we, mem_re, load_out;
    logic [ADDR_W-1:0] wr_addr, rd_addr, mem_addr;
    logic [REM_W-1:0]  den_sh_x, den_sh_y;
    logic [SRC_SIZE_W-1:0] w_m1, h_m1;
    logic [Q_W-1:0]    sx, sy;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign w_eff  = SRC_SIZE_W'(clamp_size(OUT_SIZE_W'(r_src_w), OUT_SIZE_W'(MAX_SRC_WIDTH)));
    assign h_eff  = SRC_SIZE_W'(clamp_size(OUT_SIZE_W'(r_src_h), OUT_SIZE_W'(MAX_SRC_HEIGHT)));
    assign ow_eff = clamp_size(r_out_w, OUT_SIZE_W'(MAX_OUT_SIZE));
    assign oh_eff = clamp_size(r_out_h, OUT_SIZE_W'(MAX_OUT_SIZE));

    assign is_read      = (t_op'(i_op) == OP_READ);
    assign rd_range_err = (OUT_SIZE_W'(i_col) >= ow_eff) || (OUT_SIZE_W'(i_row) >= oh_eff);
    assign wr_in_range  = (i_col < COORD_W'(w_eff)) && (i_row < COORD_W'(h_eff));

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_SIZE_W'(SIZE_RESET);
            r_src_h <= SRC_SIZE_W'(SIZE_RESET);
            r_out_w <= OUT_SIZE_W'(SIZE_RESET);
            r_out_h <= OUT_SIZE_W'(SIZE_RESET);
        end else if (cfg_acc) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data[SRC_SIZE_W-1:0];
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data[SRC_SIZE_W-1:0];
                CFG_OUT_WIDTH:  r_out_w <= i_cfg_data[OUT_SIZE_W-1:0];
                CFG_OUT_HEIGHT: r_out_h <= i_cfg_data[OUT_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!is_read) begin
                        mem_we = wr_in_range;
                    end else if (rd_range_err) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (r_step == '0) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                mem_re  = 1'b1;
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // divider step
    assign den_sh_x = REM_W'(r_den_x) << r_step;
    assign den_sh_y = REM_W'(r_den_y) << r_step;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc && is_read) begin
            r_rem_x <= REM_W'({i_col, 1'b1}) * REM_W'(w_eff);
            r_rem_y <= REM_W'({i_row, 1'b1}) * REM_W'(h_eff);
            r_den_x <= {ow_eff, 1'b0};
            r_den_y <= {oh_eff, 1'b0};
            r_qx    <= '0;
            r_qy    <= '0;
            r_step  <= STEP_W'(Q_W - 1);
            r_err   <= rd_range_err;
        end else if (r_state == ST_DIV) begin
            if (r_rem_x >= den_sh_x) begin
                r_rem_x       <= r_rem_x - den_sh_x;
                r_qx[r_step]  <= 1'b1;
            end
            if (r_rem_y >= den_sh_y) begin
                r_rem_y       <= r_rem_y - den_sh_y;
                r_qy[r_step]  <= 1'b1;
            end
            r_step <= r_step - STEP_W'(1);
        end
    end

    // clamp to last source index
    assign w_m1 = w_eff - SRC_SIZE_W'(1);
    assign h_m1 = h_eff - SRC_SIZE_W'(1);
    assign sx   = (SRC_SIZE_W'(r_qx) > w_m1) ? Q_W'(w_m1) : r_qx;
    assign sy   = (SRC_SIZE_W'(r_qy) > h_m1) ? Q_W'(h_m1) : r_qy;

    assign wr_addr  = ADDR_W'(i_row) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(i_col);
    assign rd_addr  = ADDR_W'(sy) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(sx);
    assign mem_addr = mem_re ? rd_addr : wr_addr;

    // frame store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= i_pixel;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_pixel_out   <= r_err ? '0 : r_rdata;
            r_range_error <= r_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_out   = r_pixel_out;
    assign o_range_error = r_range_error;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error) |-> (o_pixel_out == '0))
        else $error("range error word carries nonzero pixel");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_read && !o_out_valid) |=> !o_out_valid)
        else $error("write word produced a result");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_step == '0) |=> (r_state == ST_RD))
        else $error("divider did not hand over to store read");

    a_rd_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |=> (r_state == ST_RESP && !o_in_stall == 1'b0))
        else $error("store read not followed by response");

    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out) |-> (r_state == ST_RESP && out_free))
        else $error("output loaded outside response state");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-neighbor image scaler. A stimulus
// table covers the store corners, ignored writes and out-of-range reads.
// Random phases follow, each under its own size setting. A local copy of
// the frame store predicts each read but those of typed table rows. Reads
// never touch an unwritten pixel. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;

    import nnis_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_DIR        = 19;
    localparam int N_PHASES     = 11;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic             err;
    } t_pixel_word;

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pix;
        logic               typed;
        logic [PIX_W-1:0]   exp_px;
        logic               exp_err;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_op;
    logic [COORD_W-1:0]    i_col;
    logic [COORD_W-1:0]    i_row;
    logic [PIX_W-1:0]      i_pixel;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_range_error;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic [PIX_W-1:0] frame_copy [STORE_DEPTH];
    bit               written_map [STORE_DEPTH];
    logic [SRC_SIZE_W-1:0] cfg_src_w;
    logic [SRC_SIZE_W-1:0] cfg_src_h;
    logic [OUT_SIZE_W-1:0] cfg_out_w;
    logic [OUT_SIZE_W-1:0] cfg_out_h;

    t_pixel_word pending_pixels [$];
    t_stim_row   dir_rows [N_DIR];
    int          mismatches;
    int          cycles;
    int          gap_pct;
    int          stall_pct;
    int          stall_left;
    bit          calm;

    nearest_neighbor_image_scaler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_col         (i_col),
        .i_row         (i_row),
        .i_pixel       (i_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_out   (o_pixel_out),
        .o_range_error (o_range_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned limit_size(int unsigned v, int unsigned maxv);
        if (v == 0) begin
            return 1;
        end
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic int unsigned source_index(int unsigned o, int unsigned src,
                                                 int unsigned outsz);
        longint unsigned num;
        longint unsigned q;
        num = (2 * longint'(o) + 1) * longint'(src);
        q   = num / (2 * longint'(outsz));
        if (q > src - 1) begin
            q = src - 1;
        end
        return int'(q);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    // predicted effect of one accepted word
    task automatic resample_word(t_op op, logic [COORD_W-1:0] col,
                                 logic [COORD_W-1:0] row, logic [PIX_W-1:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned ow;
        int unsigned oh;
        int unsigned idx;
        t_pixel_word r;
        w  = limit_size(cfg_src_w, MAX_SRC_WIDTH);
        h  = limit_size(cfg_src_h, MAX_SRC_HEIGHT);
        ow = limit_size(cfg_out_w, MAX_OUT_SIZE);
        oh = limit_size(cfg_out_h, MAX_OUT_SIZE);
        if (op == OP_WRITE) begin
            if (col < w && row < h) begin
                idx = row * MAX_SRC_WIDTH + col;
                frame_copy[idx]  = pix;
                written_map[idx] = 1'b1;
            end
        end else begin
            if (col >= ow || row >= oh) begin
                r = '{px: '0, err: 1'b1};
            end else begin
                idx = source_index(row, h, oh) * MAX_SRC_WIDTH + source_index(col, w, ow);
                r = '{px: frame_copy[idx], err: 1'b0};
            end
            pending_pixels.push_back(r);
        end
    endtask

    task automatic send_word(t_op op, logic [COORD_W-1:0] col,
                             logic [COORD_W-1:0] row, logic [PIX_W-1:0] pix);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_op       = op;
        i_col      = col;
        i_row      = row;
        i_pixel    = pix;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic issue_word(t_op op, logic [COORD_W-1:0] col,
                              logic [COORD_W-1:0] row, logic [PIX_W-1:0] pix);
        send_word(op, col, row, pix);
        resample_word(op, col, row, pix);
    endtask

    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SRC_WIDTH:  cfg_src_w = data[SRC_SIZE_W-1:0];
            CFG_SRC_HEIGHT: cfg_src_h = data[SRC_SIZE_W-1:0];
            CFG_OUT_WIDTH:  cfg_out_w = data;
            CFG_OUT_HEIGHT: cfg_out_h = data;
            default: ;
        endcase
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                             logic [CFG_DATA_W-1:0] ow, logic [CFG_DATA_W-1:0] oh);
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        write_reg(CFG_OUT_WIDTH, ow);
        write_reg(CFG_OUT_HEIGHT, oh);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // receiver stall bursts
    initial begin
        i_out_stall = 1'b0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && !calm && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 15);
            end
            i_out_stall = (stall_left != 0);
            if (stall_left != 0) begin
                stall_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pixel_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("result word with nothing pending");
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_out !== want.px) begin
                    report_mismatch($sformatf("pixel_out %h, want %h", o_pixel_out, want.px));
                end
                if (o_range_error !== want.err) begin
                    report_mismatch($sformatf("range_error %b, want %b",
                                              o_range_error, want.err));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int unsigned p;
        int unsigned n;
        int unsigned count;
        int unsigned kind;
        int unsigned w;
        int unsigned h;
        int unsigned ow;
        int unsigned oh;
        int unsigned sx;
        int unsigned sy;
        logic [CFG_DATA_W-1:0] pw;
        logic [CFG_DATA_W-1:0] ph;
        logic [CFG_DATA_W-1:0] pow;
        logic [CFG_DATA_W-1:0] poh;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        bit oob;

        mismatches  = 0;
        cycles      = 0;
        calm        = 1'b0;
        gap_pct     = 20;
        stall_pct   = 10;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = OP_WRITE;
        i_col       = '0;
        i_row       = '0;
        i_pixel     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SRC_WIDTH;
        i_cfg_data  = '0;
        cfg_src_w   = SRC_SIZE_W'(SIZE_RESET);
        cfg_src_h   = SRC_SIZE_W'(SIZE_RESET);
        cfg_out_w   = OUT_SIZE_W'(SIZE_RESET);
        cfg_out_h   = OUT_SIZE_W'(SIZE_RESET);

        // reset sizes map 256 x 256 onto itself
        dir_rows[0]  = '{OP_WRITE, 10'd0,    10'd0,    32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0};
        dir_rows[1]  = '{OP_READ,  10'd0,    10'd0,    32'h0,         1'b1, 32'hFFFF_FFFF, 1'b0};
        dir_rows[2]  = '{OP_WRITE, 10'd255,  10'd255,  32'h0,         1'b0, 32'h0, 1'b0};
        dir_rows[3]  = '{OP_READ,  10'd255,  10'd255,  32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0};
        dir_rows[4]  = '{OP_WRITE, 10'd255,  10'd0,    32'hA5A5_A5A5, 1'b0, 32'h0, 1'b0};
        dir_rows[5]  = '{OP_READ,  10'd255,  10'd0,    32'h0,         1'b1, 32'hA5A5_A5A5, 1'b0};
        dir_rows[6]  = '{OP_WRITE, 10'd0,    10'd255,  32'h5A5A_5A5A, 1'b0, 32'h0, 1'b0};
        dir_rows[7]  = '{OP_READ,  10'd0,    10'd255,  32'h0,         1'b1, 32'h5A5A_5A5A, 1'b0};
        dir_rows[8]  = '{OP_WRITE, 10'd256,  10'd0,    32'h1234_5678, 1'b0, 32'h0, 1'b0};
        dir_rows[9]  = '{OP_WRITE, 10'd0,    10'd256,  32'h8765_4321, 1'b0, 32'h0, 1'b0};
        dir_rows[10] = '{OP_WRITE, 10'd1023, 10'd1023, 32'hDEAD_BEEF, 1'b0, 32'h0, 1'b0};
        dir_rows[11] = '{OP_READ,  10'd0,    10'd0,    32'h0,         1'b1, 32'hFFFF_FFFF, 1'b0};
        dir_rows[12] = '{OP_READ,  10'd256,  10'd0,    32'h0,         1'b1, 32'h0, 1'b1};
        dir_rows[13] = '{OP_READ,  10'd0,    10'd256,  32'h0,         1'b1, 32'h0, 1'b1};
        dir_rows[14] = '{OP_READ,  10'd1023, 10'd1023, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1};
        dir_rows[15] = '{OP_READ,  10'd1023, 10'd0,    32'h0,         1'b1, 32'h0, 1'b1};
        dir_rows[16] = '{OP_WRITE, 10'd1,    10'd1,    32'h0F0F_0F0F, 1'b0, 32'h0, 1'b0};
        dir_rows[17] = '{OP_READ,  10'd1,    10'd1,    32'h0,         1'b0, 32'h0, 1'b0};
        dir_rows[18] = '{OP_READ,  10'd255,  10'd0,    32'h0,         1'b0, 32'h0, 1'b0};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (n = 0; n < N_DIR; n++) begin
            maybe_pause();
            send_word(dir_rows[n].op, dir_rows[n].col, dir_rows[n].row, dir_rows[n].pix);
            if (dir_rows[n].typed) begin
                pending_pixels.push_back('{px: dir_rows[n].exp_px, err: dir_rows[n].exp_err});
            end else begin
                resample_word(dir_rows[n].op, dir_rows[n].col, dir_rows[n].row,
                              dir_rows[n].pix);
            end
        end

        for (p = 0; p < N_PHASES; p++) begin
            drain_results();
            count = 80;
            case (p)
                0: begin pw = 1;   ph = 1;   pow = 1;    poh = 1;    count = 50;  end
                1: begin pw = 256; ph = 256; pow = 1024; poh = 1024; count = 100; end
                2: begin pw = 0;   ph = 0;   pow = 0;    poh = 0;    count = 40;  end
                3: begin pw = 511; ph = 511; pow = 2047; poh = 2047; end
                4: begin pw = 7;   ph = 5;   pow = 23;   poh = 19;   count = 90;  end
                5: begin pw = 200; ph = 150; pow = 9;    poh = 6;    count = 90;  end
                6: begin
                    pw  = $urandom_range(1, 511);
                    ph  = $urandom_range(1, 511);
                    pow = $urandom_range(1, 2047);
                    poh = $urandom_range(1, 2047);
                end
                default: begin
                    // upper data bits fall outside the source size registers
                    pw  = {2'($urandom()), 9'($urandom_range(1, 32))};
                    ph  = {2'($urandom()), 9'($urandom_range(1, 32))};
                    pow = $urandom_range(1, 64);
                    poh = $urandom_range(1, 64);
                end
            endcase
            configure(pw, ph, pow, poh);
            calm      = (p == N_PHASES - 1);
            gap_pct   = $urandom_range(0, 2) * 15;
            stall_pct = $urandom_range(0, 2) * 10;
            w  = limit_size(cfg_src_w, MAX_SRC_WIDTH);
            h  = limit_size(cfg_src_h, MAX_SRC_HEIGHT);
            ow = limit_size(cfg_out_w, MAX_OUT_SIZE);
            oh = limit_size(cfg_out_h, MAX_OUT_SIZE);

            for (n = 0; n < count; n++) begin
                maybe_pause();
                kind = $urandom_range(0, 99);
                oob  = 1'b0;
                if (kind < 25) begin
                    issue_word(OP_WRITE, COORD_W'($urandom_range(0, w - 1)),
                               COORD_W'($urandom_range(0, h - 1)), $urandom());
                end else if (kind < 33) begin
                    issue_word(OP_WRITE, COORD_W'($urandom()), COORD_W'($urandom()),
                               $urandom());
                end else begin
                    if (kind < 43) begin
                        if (ow < 1024 && ($urandom_range(0, 1) == 1 || oh >= 1024)) begin
                            col = COORD_W'($urandom_range(ow, 1023));
                            row = COORD_W'($urandom());
                            oob = 1'b1;
                        end else if (oh < 1024) begin
                            col = COORD_W'($urandom());
                            row = COORD_W'($urandom_range(oh, 1023));
                            oob = 1'b1;
                        end
                    end
                    if (!oob) begin
                        col = COORD_W'($urandom_range(0, ow - 1));
                        row = COORD_W'($urandom_range(0, oh - 1));
                        sx  = source_index(col, w, ow);
                        sy  = source_index(row, h, oh);
                        // fill the sampled pixel first if it was never written
                        if (!written_map[sy * MAX_SRC_WIDTH + sx]) begin
                            issue_word(OP_WRITE, COORD_W'(sx), COORD_W'(sy), $urandom());
                            n++;
                        end
                    end
                    issue_word(OP_READ, col, row, $urandom());
                end
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
